// ===== rtl/core/lphm_pkg.sv =====
package lphm_pkg;

	localparam logic [63:0] HASH_MUL   = 64'hff51afd7ed558ccd;
	localparam int          HASH_SHIFT = 33;
	localparam int          LOAD_NUM   = 3;
	localparam int          LOAD_DEN   = 4;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2,
		ST_ZERO = 2'd3
	} status_t;

	typedef struct packed {
		logic        mode;
		logic [63:0] key;
		logic [31:0] value;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] value_out;
	} rsp_t;

	// Datapath operations issued by the controller, one per cycle.
	typedef enum logic [4:0] {
		OP_NONE,
		OP_CLR,
		OP_LOAD,
		OP_ZERO,
		OP_MUL0,
		OP_MUL1,
		OP_MUL2,
		OP_ADD,
		OP_HOME,
		OP_MOD,
		OP_NEXT,
		OP_HIT,
		OP_OVERWRITE,
		OP_MISS,
		OP_FULL,
		OP_INSERT,
		OP_PUSH
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} cmd_t;

	typedef struct packed {
		logic key_zero;
		logic mode_ins;
		logic hit;
		logic empty;
		logic full;
		logic home_ready;
		logic clr_last;
		logic out_busy;
	} sts_t;

endpackage

// ===== rtl/core/lphm_ifs.sv =====
interface lphm_req_if;
	logic        valid;
	logic        ready;
	logic        mode;
	logic [63:0] key;
	logic [31:0] value;

	modport source (output valid, output mode, output key, output value, input ready);
	modport sink (input valid, input mode, input key, input value, output ready);
endinterface

interface lphm_rsp_if;
	logic                 valid;
	logic                 ready;
	lphm_pkg::status_t    status;
	logic [31:0]          value_out;

	modport source (output valid, output status, output value_out, input ready);
	modport sink (input valid, input status, input value_out, output ready);
endinterface

// ===== rtl/core/lphm_ctrl.sv =====
module lphm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lphm_pkg::sts_t sts,
	output lphm_pkg::cmd_t cmd
);

	typedef enum logic [10:0] {
		S_CLEAR = 11'b00000000001,
		S_IDLE  = 11'b00000000010,
		S_MUL0  = 11'b00000000100,
		S_MUL1  = 11'b00000001000,
		S_MUL2  = 11'b00000010000,
		S_ADD   = 11'b00000100000,
		S_HOME  = 11'b00001000000,
		S_MOD   = 11'b00010000000,
		S_READ  = 11'b00100000000,
		S_CMP   = 11'b01000000000,
		S_DONE  = 11'b10000000000
	} state_t;

	state_t state_q, state_d;

	assign req_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = lphm_pkg::OP_NONE;
		case (state_q)
			S_CLEAR: begin
				cmd.op = lphm_pkg::OP_CLR;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (req_valid) begin
					cmd.op  = lphm_pkg::OP_LOAD;
					state_d = S_MUL0;
				end
			end
			S_MUL0: begin
				if (sts.key_zero) begin
					cmd.op  = lphm_pkg::OP_ZERO;
					state_d = S_DONE;
				end else begin
					cmd.op  = lphm_pkg::OP_MUL0;
					state_d = S_MUL1;
				end
			end
			S_MUL1: begin
				cmd.op  = lphm_pkg::OP_MUL1;
				state_d = S_MUL2;
			end
			S_MUL2: begin
				cmd.op  = lphm_pkg::OP_MUL2;
				state_d = S_ADD;
			end
			S_ADD: begin
				cmd.op  = lphm_pkg::OP_ADD;
				state_d = S_HOME;
			end
			S_HOME: begin
				cmd.op  = lphm_pkg::OP_HOME;
				state_d = S_MOD;
			end
			S_MOD: begin
				if (sts.home_ready) begin
					state_d = S_READ;
				end else begin
					cmd.op = lphm_pkg::OP_MOD;
				end
			end
			S_READ: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				if (sts.hit) begin
					cmd.op  = sts.mode_ins ? lphm_pkg::OP_OVERWRITE : lphm_pkg::OP_HIT;
					state_d = S_DONE;
				end else if (sts.empty) begin
					if (!sts.mode_ins) begin
						cmd.op = lphm_pkg::OP_MISS;
					end else if (sts.full) begin
						cmd.op = lphm_pkg::OP_FULL;
					end else begin
						cmd.op = lphm_pkg::OP_INSERT;
					end
					state_d = S_DONE;
				end else begin
					cmd.op  = lphm_pkg::OP_NEXT;
					state_d = S_READ;
				end
			end
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.op  = lphm_pkg::OP_PUSH;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== rtl/core/lphm_dp.sv =====
module lphm_dp #(
	parameter int TABLE_SLOTS = 1024
) (
	input  logic           clk,
	input  logic           arst_n,
	input  lphm_pkg::req_t req,
	input  lphm_pkg::cmd_t cmd,
	output lphm_pkg::sts_t sts,
	output logic           out_valid,
	input  logic           out_ready,
	output lphm_pkg::rsp_t out_data
);

	localparam int IDX_W = $clog2(TABLE_SLOTS);
	localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
	localparam bit POW2  = (TABLE_SLOTS & (TABLE_SLOTS - 1)) == 0;
	localparam logic [CNT_W-1:0] LIMIT =
		CNT_W'((lphm_pkg::LOAD_NUM * TABLE_SLOTS + lphm_pkg::LOAD_DEN - 1) / lphm_pkg::LOAD_DEN);
	localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(TABLE_SLOTS - 1);
	localparam logic [31:0]      MOD_N     = 32'(TABLE_SLOTS);
	localparam logic [31:0]      MOD_RECIP = 32'(64'h1_0000_0000 / 64'(TABLE_SLOTS));
	localparam logic [5:0]       MOD_STEPS = 6'd3;

	logic [63:0] keys_mem [TABLE_SLOTS];
	logic [31:0] vals_mem [TABLE_SLOTS];

	logic [IDX_W-1:0] clr_q;
	logic [CNT_W-1:0] used_q;
	logic [IDX_W-1:0] pos_q;
	logic [5:0]       mod_cnt_q;
	logic [31:0]      mod_dvd_q;
	logic             out_valid_q;

	logic             mode_q;
	logic [63:0]      key_q;
	logic [31:0]      val_q;
	logic [63:0]      x_q;
	logic [63:0]      mul_q;
	logic [31:0]      y_lo_q;
	logic [31:0]      y_hi_q;
	logic [63:0]      rd_key_q;
	logic [31:0]      rd_val_q;
	lphm_pkg::rsp_t   res_q;
	lphm_pkg::rsp_t   out_q;

	logic [31:0]      mul_a;
	logic [31:0]      mul_b;
	logic [31:0]      hash32;
	logic [31:0]      mod_diff;
	logic [IDX_W-1:0] mod_rem_d;
	logic [IDX_W-1:0] pos_inc;

	// One shared 32x32 multiplier builds the low 64 bits of x * HASH_MUL
	// from three partial products over consecutive cycles.
	always_comb begin
		case (cmd.op)
			lphm_pkg::OP_MUL1: begin
				mul_a = x_q[63:32];
				mul_b = lphm_pkg::HASH_MUL[31:0];
			end
			lphm_pkg::OP_MUL2: begin
				mul_a = x_q[31:0];
				mul_b = lphm_pkg::HASH_MUL[63:32];
			end
			lphm_pkg::OP_MOD: begin
				if (mod_cnt_q == MOD_STEPS) begin
					mul_a = mod_dvd_q;
					mul_b = MOD_RECIP;
				end else begin
					mul_a = mul_q[63:32];
					mul_b = MOD_N;
				end
			end
			default: begin
				mul_a = x_q[31:0];
				mul_b = lphm_pkg::HASH_MUL[31:0];
			end
		endcase
	end

	assign hash32 = 32'({y_hi_q, y_lo_q} ^ ({y_hi_q, y_lo_q} >> lphm_pkg::HASH_SHIFT));

	// The quotient estimate from the reciprocal is at most one short, so a
	// single compare and subtract finishes the remainder.
	assign mod_diff  = mod_dvd_q - mul_q[31:0];
	assign mod_rem_d = (mod_diff >= MOD_N) ? IDX_W'(mod_diff - MOD_N) : IDX_W'(mod_diff);

	assign pos_inc = (pos_q == LAST_IDX) ? '0 : pos_q + IDX_W'(1);

	assign sts.key_zero   = (key_q == 64'd0);
	assign sts.mode_ins   = mode_q;
	assign sts.hit        = (rd_key_q == key_q);
	assign sts.empty      = (rd_key_q == 64'd0);
	assign sts.full       = (used_q >= LIMIT);
	assign sts.home_ready = (mod_cnt_q == 6'd0);
	assign sts.clr_last   = (clr_q == LAST_IDX);
	assign sts.out_busy   = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_ff @(posedge clk) begin
		rd_key_q <= keys_mem[pos_q];
		rd_val_q <= vals_mem[pos_q];
		if (cmd.op == lphm_pkg::OP_CLR) begin
			keys_mem[clr_q] <= 64'd0;
		end else if (cmd.op == lphm_pkg::OP_INSERT) begin
			keys_mem[pos_q] <= key_q;
		end
		if (cmd.op == lphm_pkg::OP_INSERT || cmd.op == lphm_pkg::OP_OVERWRITE) begin
			vals_mem[pos_q] <= val_q;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			lphm_pkg::OP_LOAD: begin
				mode_q <= req.mode;
				key_q  <= req.key;
				val_q  <= req.value;
				x_q    <= req.key ^ (req.key >> lphm_pkg::HASH_SHIFT);
			end
			lphm_pkg::OP_MUL0: begin
				mul_q <= mul_a * mul_b;
			end
			lphm_pkg::OP_MUL1: begin
				y_lo_q <= mul_q[31:0];
				y_hi_q <= mul_q[63:32];
				mul_q  <= mul_a * mul_b;
			end
			lphm_pkg::OP_MUL2: begin
				y_hi_q <= y_hi_q + mul_q[31:0];
				mul_q  <= mul_a * mul_b;
			end
			lphm_pkg::OP_ADD: begin
				y_hi_q <= y_hi_q + mul_q[31:0];
			end
			lphm_pkg::OP_MOD: begin
				mul_q <= mul_a * mul_b;
			end
			lphm_pkg::OP_ZERO: begin
				res_q <= '{status: lphm_pkg::ST_ZERO, value_out: 32'd0};
			end
			lphm_pkg::OP_HIT: begin
				res_q <= '{status: lphm_pkg::ST_OK, value_out: rd_val_q};
			end
			lphm_pkg::OP_OVERWRITE, lphm_pkg::OP_INSERT: begin
				res_q <= '{status: lphm_pkg::ST_OK, value_out: 32'd0};
			end
			lphm_pkg::OP_MISS: begin
				res_q <= '{status: lphm_pkg::ST_MISS, value_out: 32'd0};
			end
			lphm_pkg::OP_FULL: begin
				res_q <= '{status: lphm_pkg::ST_FULL, value_out: 32'd0};
			end
			lphm_pkg::OP_PUSH: begin
				out_q <= res_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			used_q      <= '0;
			pos_q       <= '0;
			mod_cnt_q   <= '0;
			mod_dvd_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.op == lphm_pkg::OP_CLR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
			if (cmd.op == lphm_pkg::OP_INSERT) begin
				used_q <= used_q + CNT_W'(1);
			end
			if (cmd.op == lphm_pkg::OP_HOME) begin
				if (POW2) begin
					pos_q     <= hash32[IDX_W-1:0];
					mod_cnt_q <= 6'd0;
				end else begin
					mod_dvd_q <= hash32;
					mod_cnt_q <= MOD_STEPS;
				end
			end else if (cmd.op == lphm_pkg::OP_MOD && mod_cnt_q != 6'd0) begin
				mod_cnt_q <= mod_cnt_q - 6'd1;
				if (mod_cnt_q == 6'd1) begin
					pos_q <= mod_rem_d;
				end
			end else if (cmd.op == lphm_pkg::OP_NEXT) begin
				pos_q <= pos_inc;
			end
			if (cmd.op == lphm_pkg::OP_PUSH) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// The load limit must always leave an empty slot for probing to stop.
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= LIMIT)
		else $error("occupancy above load limit");

	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == lphm_pkg::OP_PUSH) |-> !(out_valid_q && !out_ready))
		else $error("result pushed over a waiting result");

	a_insert_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == lphm_pkg::OP_INSERT) |-> (rd_key_q == 64'd0 && !sts.full))
		else $error("insert into an occupied slot or a full table");

	a_used_inc: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == lphm_pkg::OP_INSERT) |=> (used_q == $past(used_q) + CNT_W'(1)))
		else $error("occupancy count not advanced on insert");

endmodule

// ===== rtl/core/linear_probe_hash_map_core.sv =====
// A result is registered after the hash steps and P >= 1 probed slots; a table size that is
// not a power of two adds 3 remainder steps. A zero key answers without hashing or probing.
// The next item is taken once the previous result is pushed to the output register, even while
// that result still waits; each probe costs one memory read and compare.
// Reset: a clearing pass writes every key slot to empty, with req.ready low until it ends.
module linear_probe_hash_map_core #(
	parameter int TABLE_SLOTS = 1024
) (
	input logic         clk,
	input logic         arst_n,
	lphm_req_if.sink    req,
	lphm_rsp_if.source  rsp
);

	lphm_pkg::cmd_t cmd;
	lphm_pkg::sts_t sts;
	lphm_pkg::req_t req_data;
	lphm_pkg::rsp_t rsp_data;
	logic           ready;
	logic           out_valid;

	assign req_data = '{mode: req.mode, key: req.key, value: req.value};
	assign req.ready = ready;

	assign rsp.valid     = out_valid;
	assign rsp.status    = rsp_data.status;
	assign rsp.value_out = rsp_data.value_out;

	lphm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	lphm_dp #(
		.TABLE_SLOTS (TABLE_SLOTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (rsp.ready),
		.out_data  (rsp_data)
	);

endmodule
